>>> rtl/core/rdrl_pkg.sv
// rdrl_pkg: shared types and constants for the request dedup rate limiter
// no dependencies; imported by rdrl_ctrl, rdrl_dpath and the top level
`default_nettype none

package rdrl_pkg;

    // recent-id ring geometry
    localparam int ID_DEPTH = 16;
    localparam int IDX_W    = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
    // width that holds both a ring age and the ids_kept register
    localparam int AGE_W    = ((IDX_W > 5) ? IDX_W : 5) + 1;

    // field widths
    localparam int ID_W     = 32;
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 17;
    localparam int STRIKE_W = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // limiter constants
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [STRIKE_W-1:0] STRIKE_MAX   = '1;
    localparam logic [STRIKE_W-1:0] STRIKE_LIMIT = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDS_KEPT       = 8'd3;

    // configuration reset values
    localparam logic [31:0] RST_WINDOW_TICKS   = 32'd1000;
    localparam logic [15:0] RST_MAX_PER_WINDOW = 16'd10;
    localparam logic [31:0] RST_BLOCK_TICKS    = 32'd1000;
    localparam logic [4:0]  RST_IDS_KEPT       = 5'd16;

    // verdict codes
    localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [1:0] VERDICT_DUP     = 2'd1;
    localparam logic [1:0] VERDICT_LIMITED = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;  // capture input transfer
        logic eval;     // register the compare results
        logic commit;   // update limiter state and load result
    } ctl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/rdrl_ctrl.sv
// rdrl_ctrl: sequencing state machine and output valid tracking
// depends on rdrl_pkg
`default_nettype none

module rdrl_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      rdrl_pkg::ctl_cmd_t cmd
);
    import rdrl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;
    logic   load;

    // result may be loaded when the output register is empty or draining
    assign commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE) || commit;
    assign load     = in_valid && in_ready;

    assign cmd.load_in = load;
    assign cmd.eval    = (state_reg == ST_EVAL);
    assign cmd.commit  = commit;
    assign out_valid   = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = load ? ST_EVAL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on commit, cleared on transfer
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rdrl_dpath.sv
// rdrl_dpath: config registers, recent-id ring, window limiter and result register
// depends on rdrl_pkg; driven by rdrl_ctrl commands
`default_nettype none

module rdrl_dpath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rdrl_pkg::ctl_cmd_t                   cmd,
    input  wire logic signed [rdrl_pkg::ID_W-1:0]     request_id,
    input  wire logic        [rdrl_pkg::TIME_W-1:0]   now_ticks,
    input  wire logic                                 cfg_we,
    input  wire logic        [rdrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [rdrl_pkg::CFG_DATA_W-1:0] cfg_data,
    output      logic        [1:0]                    verdict,
    output      logic signed [rdrl_pkg::ID_W-1:0]     echo_id
);
    import rdrl_pkg::*;

    // configuration
    logic [31:0] win_ticks_reg;
    logic [15:0] max_win_reg;
    logic [31:0] blk_ticks_reg;
    logic [4:0]  ids_kept_reg;

    // captured request
    logic signed [ID_W-1:0] req_id_reg;
    logic [TIME_W-1:0]      now_reg;

    // limiter state
    logic [TIME_W-1:0]   win_start_reg, win_start_next;
    logic [COUNT_W-1:0]  win_count_reg, win_count_next;
    logic [STRIKE_W-1:0] strikes_reg, strikes_next;
    logic [TIME_W-1:0]   blk_until_reg, blk_until_next;

    // recent-id ring
    logic [ID_W-1:0]     ring_reg [ID_DEPTH];
    logic [ID_DEPTH-1:0] ring_vld_reg, ring_vld_next;
    logic [IDX_W-1:0]    head_reg, head_next;

    // evaluation stage results
    logic              dup_reg, dup_next;
    logic              blocked_reg, blocked_next;
    logic              expired_reg, expired_next;
    logic [TIME_W-1:0] until_reg, until_next;

    // result register
    logic [1:0]             verdict_reg, verdict_next;
    logic signed [ID_W-1:0] echo_reg;

    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W:0]     until_sum;
    logic                hit;
    logic [STRIKE_W-1:0] strikes_a;
    logic [STRIKE_W-1:0] strikes_b;
    logic [COUNT_W-1:0]  count_a;
    logic [COUNT_W-1:0]  count_b;
    logic                admit;
    logic [AGE_W-1:0]    age;

    // ring lookup over all valid entries
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < ID_DEPTH; i++)
        begin
            if (ring_vld_reg[i] && (ring_reg[i] == req_id_reg))
            begin
                hit = 1'b1;
            end
        end
    end

    // stage one: duplicate, block and window expiry checks
    always_comb
    begin
        elapsed      = now_reg - win_start_reg;
        dup_next     = (req_id_reg == '0) || req_id_reg[ID_W-1] || hit;
        blocked_next = now_reg < blk_until_reg;
        expired_next = (win_ticks_reg == '0)
                    || ((now_reg >= win_start_reg) && (elapsed >= TIME_W'(win_ticks_reg)));
        until_sum    = {1'b0, now_reg} + (TIME_W + 1)'(blk_ticks_reg);
        until_next   = until_sum[TIME_W] ? '1 : until_sum[TIME_W-1:0];
    end

    // stage two: limiter update and verdict
    always_comb
    begin
        win_start_next = win_start_reg;
        win_count_next = win_count_reg;
        strikes_next   = strikes_reg;
        blk_until_next = blk_until_reg;
        admit          = 1'b0;

        // window restart settles the strike count from the old window
        if (expired_reg)
        begin
            if (win_count_reg > COUNT_W'(max_win_reg))
            begin
                strikes_a = (strikes_reg == STRIKE_MAX) ? STRIKE_MAX : strikes_reg + 1'b1;
            end
            else
            begin
                strikes_a = '0;
            end
            count_a = '0;
        end
        else
        begin
            strikes_a = strikes_reg;
            count_a   = win_count_reg;
        end
        count_b   = (count_a == COUNT_MAX) ? COUNT_MAX : count_a + 1'b1;
        strikes_b = (strikes_a == STRIKE_MAX) ? STRIKE_MAX : strikes_a + 1'b1;

        if (dup_reg)
        begin
            verdict_next = VERDICT_DUP;
        end
        else if (blocked_reg)
        begin
            verdict_next = VERDICT_LIMITED;
        end
        else
        begin
            if (expired_reg)
            begin
                win_start_next = now_reg;
            end
            win_count_next = count_b;
            if (count_b <= COUNT_W'(max_win_reg))
            begin
                admit        = 1'b1;
                strikes_next = strikes_a;
                verdict_next = VERDICT_ACCEPT;
            end
            else
            begin
                verdict_next = VERDICT_LIMITED;
                // three strikes start a block
                if (strikes_b >= STRIKE_LIMIT)
                begin
                    blk_until_next = until_reg;
                    strikes_next   = '0;
                end
                else
                begin
                    strikes_next = strikes_b;
                end
            end
        end
    end

    // ring push with trimming by age against ids_kept
    always_comb
    begin
        head_next     = (head_reg == IDX_W'(ID_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        ring_vld_next = ring_vld_reg;
        for (int i = 0; i < ID_DEPTH; i++)
        begin
            if (AGE_W'(head_reg) >= AGE_W'(i))
            begin
                age = AGE_W'(head_reg) - AGE_W'(i);
            end
            else
            begin
                age = AGE_W'(head_reg) + AGE_W'(ID_DEPTH) - AGE_W'(i);
            end
            ring_vld_next[i] = ((IDX_W'(i) == head_reg) || ring_vld_reg[i])
                            && (age < AGE_W'(ids_kept_reg));
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_ticks_reg <= RST_WINDOW_TICKS;
            max_win_reg   <= RST_MAX_PER_WINDOW;
            blk_ticks_reg <= RST_BLOCK_TICKS;
            ids_kept_reg  <= RST_IDS_KEPT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_TICKS:   win_ticks_reg <= cfg_data;
                CFG_MAX_PER_WINDOW: max_win_reg   <= cfg_data[15:0];
                CFG_BLOCK_TICKS:    blk_ticks_reg <= cfg_data;
                CFG_IDS_KEPT:       ids_kept_reg  <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // limiter and ring control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= '0;
            win_count_reg <= '0;
            strikes_reg   <= '0;
            blk_until_reg <= '0;
            ring_vld_reg  <= '0;
            head_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            win_start_reg <= win_start_next;
            win_count_reg <= win_count_next;
            strikes_reg   <= strikes_next;
            blk_until_reg <= blk_until_next;
            if (admit)
            begin
                ring_vld_reg <= ring_vld_next;
                head_reg     <= head_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_id_reg <= request_id;
            now_reg    <= now_ticks;
        end
        if (cmd.eval)
        begin
            dup_reg     <= dup_next;
            blocked_reg <= blocked_next;
            expired_reg <= expired_next;
            until_reg   <= until_next;
        end
        if (cmd.commit)
        begin
            verdict_reg <= verdict_next;
            echo_reg    <= req_id_reg;
            if (admit)
            begin
                ring_reg[head_reg] <= req_id_reg;
            end
        end
    end

    assign verdict = verdict_reg;
    assign echo_id = echo_reg;

endmodule

`default_nettype wire

>>> rtl/core/request_dedup_rate_limiter.sv
// request admission filter: replay rejection plus fixed-window rate limiter
// flow: the input is captured, then looked up, then the limiter is updated and the result
// loaded; that commit waits while a result is held unread. A new request is taken only
// while idle or in the commit step; the limiter state read-modify-write sets that limit
// reset: rst_n clears limiter state, ring valid bits and head; config returns
// to defaults; no clearing pass, in_ready is high as soon as reset is released
`default_nettype none

module request_dedup_rate_limiter
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output      logic                                  in_ready,
    input  wire logic signed [rdrl_pkg::ID_W-1:0]      request_id,
    input  wire logic        [rdrl_pkg::TIME_W-1:0]    now_ticks,
    output      logic                                  out_valid,
    input  wire logic                                  out_ready,
    output      logic        [1:0]                     verdict,
    output      logic signed [rdrl_pkg::ID_W-1:0]      echo_id,
    input  wire logic                                  cfg_valid,
    output      logic                                  cfg_ready,
    input  wire logic        [rdrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [rdrl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rdrl_pkg::*;

    ctl_cmd_t cmd;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    rdrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rdrl_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .request_id (request_id),
        .now_ticks  (now_ticks),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .verdict    (verdict),
        .echo_id    (echo_id)
    );

endmodule

`default_nettype wire
